FILE: hdl/depth_pixel_to_world_point_core_assert.svh
// Assertion macros shared by the depth-to-world RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_CORE_ASSERT_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DPW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/dpw_pkg.sv
// Shared types and constants for the depth pixel to world point core.
// No dependencies; every RTL module file imports this package.
`default_nettype none

package dpw_pkg;

	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;

	typedef enum logic [2:0] {
		REG_PRINCIPAL   = 3'd0,
		REG_INV_FX      = 3'd1,
		REG_INV_FY      = 3'd2,
		REG_ROW_X       = 3'd3,
		REG_ROW_Y       = 3'd4,
		REG_ROW_Z       = 3'd5,
		REG_COLOR_ORDER = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		ORDER_RGB  = 2'd0,
		ORDER_BGR  = 2'd1,
		ORDER_MONO = 2'd2
	} color_order_t;

	localparam logic [31:0] RST_PRINCIPAL = 32'd335023864;
	localparam logic [31:0] RST_INV_F     = 32'd8181021;
	localparam logic [63:0] RST_ROW_X     = 64'h4000_0000_0000_0000;
	localparam logic [63:0] RST_ROW_Y     = 64'h0000_4000_0000_0000;
	localparam logic [63:0] RST_ROW_Z     = 64'h0000_0000_4000_0000;

	// Camera coordinates: millimetres Q.16, magnitude clamped to 45 bits.
	localparam int CAM_W = 46;
	localparam logic [CAM_W-2:0] CAM_MAX = '1;

	// Millimetres Q.30 to metres Q.16: divide by 16384000 = 2^15 * 4 * 125.
	localparam logic [63:0] ROUND_HALF = 64'd8192000;
	localparam logic [48:0] W_SAT      = 49'd1073741824000;
	localparam logic [19:0] RECIP_HI   = 20'd536871;
	localparam logic [26:0] RECIP_LO   = 27'd68719477;
	localparam logic [6:0]  DIV_D      = 7'd125;
	localparam logic [25:0] Y_LIMIT    = 26'd65536000;

	typedef struct packed {
		logic signed [15:0] r0;
		logic signed [15:0] r1;
		logic signed [15:0] r2;
		logic signed [15:0] t;
	} row_t;

	typedef struct packed {
		logic [15:0]  cx;
		logic [15:0]  cy;
		logic [31:0]  inv_fx;
		logic [31:0]  inv_fy;
		row_t [2:0]   rows;
		color_order_t color_order;
	} cfg_t;

	typedef struct packed {
		logic       pt;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} side_t;

	typedef struct packed {
		side_t                    side;
		logic signed [CAM_W-1:0]  cam_x;
		logic signed [CAM_W-1:0]  cam_y;
		logic [31:0]              cam_z;
	} cam_t;

	typedef struct packed {
		side_t           side;
		logic [2:0][63:0] s;
	} sum_t;

	typedef struct packed {
		side_t            side;
		logic [2:0][31:0] world;
	} point_t;

endpackage

`default_nettype wire

FILE: hdl/depth_pixel_to_world_point_core.sv
// Top level of the depth pixel to world point core: stream ports, APB registers.
// Depends on dpw_pkg, dpw_cfg_regs, dpw_backproj, dpw_transform, dpw_scale and the assert macros.
`default_nettype none

`include "depth_pixel_to_world_point_core_assert.svh"

// Back-projects one depth pixel per beat through a pinhole model (principal point and
// inverse focal lengths) into camera millimetres, applies a 3x4 rigid transform
// (world = r0*z - r1*x - r2*y + t per row) and emits the point in signed Q15.16 metres,
// saturated, together with the pixel colour reordered as RGB, BGR or mono. Zero depth or a
// pixel outside every detection box gives point_valid 0 and zero coordinates; outside a box
// the colour is zeroed as well. The core takes one pixel every clock cycle unless a stalled
// output has filled the pipeline. The datapath has 12 stages: four of back-projection, two
// of transform products and sums, six of rounding, the divide by 16384000 (two reciprocal
// digits) and saturation. Each stage carries its own valid bit; a stalled output fills
// pipeline bubbles before s_tready drops, so no beat is lost or repeated. Registers sit at
// byte address 8*i (principal point, 1/fx, 1/fy, transform rows x/y/z, color order) and are
// to be written only while the core is empty.
module depth_pixel_to_world_point_core import dpw_pkg::*; #(
	parameter int COORD_BITS = 12,
	localparam int IN_BITS   = 2 * COORD_BITS + 40,
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_W     = 120
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel_col, pixel_row, depth_mm, color_byte0, color_byte1, color_byte2, zero fill
	input  logic [IN_W-1:0]       s_tdata,
	// inside_box
	input  logic                  s_tuser,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// world_x, world_y, world_z, red, green, blue
	output logic [OUT_W-1:0]      m_tdata,
	// point_valid
	output logic                  m_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int OFS_D   = 2 * COORD_BITS;
	localparam int OFS_B0  = OFS_D + 16;
	localparam int OFS_B1  = OFS_B0 + 8;
	localparam int OFS_B2  = OFS_B1 + 8;

	cfg_t   cfg;
	logic   cam_valid, cam_ready;
	logic   sum_valid, sum_ready;
	cam_t   cam;
	sum_t   sum;
	point_t point;

	// Registers answer in the access cycle.
	assign pready = 1'b1;

	dpw_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Unpack the pixel beat, lowest field first.
	dpw_backproj #(
		.COORD_BITS (COORD_BITS)
	) u_backproj (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.col       (s_tdata[COORD_BITS-1:0]),
		.row       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.depth     (s_tdata[OFS_D+15:OFS_D]),
		.in_box    (s_tuser),
		.byte0     (s_tdata[OFS_B0+7:OFS_B0]),
		.byte1     (s_tdata[OFS_B1+7:OFS_B1]),
		.byte2     (s_tdata[OFS_B2+7:OFS_B2]),
		.out_valid (cam_valid),
		.out_ready (cam_ready),
		.cam       (cam)
	);

	dpw_transform u_transform (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (cam_valid),
		.in_ready  (cam_ready),
		.cam       (cam),
		.out_valid (sum_valid),
		.out_ready (sum_ready),
		.sum       (sum)
	);

	// The last scale stage is the output register.
	dpw_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_valid),
		.in_ready  (sum_ready),
		.sum       (sum),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.point     (point)
	);

	// Pack the result beat, world_x in the lowest bits.
	assign m_tdata = {point.side.blue, point.side.green, point.side.red,
		point.world[2], point.world[1], point.world[0]};
	assign m_tuser = point.side.pt;

	`DPW_ASSERT_IMP(a_invalid_point_zero, m_tvalid && !m_tuser, m_tdata[95:0] == 96'd0, "invalid point carries nonzero coordinates")
	`DPW_ASSERT_IMP(a_stall_only_on_backpressure, !s_tready, m_tvalid && !m_tready, "input stalled while pipeline has room")
	`DPW_ASSERT_NXT(a_stall_keeps_output, !s_tready, m_tvalid, "output dropped while input was stalled")

endmodule

`default_nettype wire

FILE: hdl/dpw_cfg_regs.sv
// APB register file for the depth pixel to world point core.
// Depends on dpw_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module dpw_cfg_regs import dpw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output cfg_t                  cfg
);

	logic [31:0]  principal_q;
	logic [31:0]  inv_fx_q;
	logic [31:0]  inv_fy_q;
	logic [63:0]  row_x_q;
	logic [63:0]  row_y_q;
	logic [63:0]  row_z_q;
	color_order_t color_q;
	logic         wr;
	reg_idx_t     idx;

	assign wr  = psel & penable & pwrite;
	assign idx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			principal_q <= RST_PRINCIPAL;
			inv_fx_q    <= RST_INV_F;
			inv_fy_q    <= RST_INV_F;
			row_x_q     <= RST_ROW_X;
			row_y_q     <= RST_ROW_Y;
			row_z_q     <= RST_ROW_Z;
			color_q     <= ORDER_RGB;
		end else if (wr) begin
			unique case (idx)
				REG_PRINCIPAL:   principal_q <= pwdata[31:0];
				REG_INV_FX:      inv_fx_q    <= pwdata[31:0];
				REG_INV_FY:      inv_fy_q    <= pwdata[31:0];
				REG_ROW_X:       row_x_q     <= pwdata;
				REG_ROW_Y:       row_y_q     <= pwdata;
				REG_ROW_Z:       row_z_q     <= pwdata;
				REG_COLOR_ORDER: color_q     <= color_order_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PRINCIPAL:   prdata = 64'(principal_q);
			REG_INV_FX:      prdata = 64'(inv_fx_q);
			REG_INV_FY:      prdata = 64'(inv_fy_q);
			REG_ROW_X:       prdata = row_x_q;
			REG_ROW_Y:       prdata = row_y_q;
			REG_ROW_Z:       prdata = row_z_q;
			REG_COLOR_ORDER: prdata = 64'(color_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.cx          = principal_q[31:16];
	assign cfg.cy          = principal_q[15:0];
	assign cfg.inv_fx      = inv_fx_q;
	assign cfg.inv_fy      = inv_fy_q;
	assign cfg.rows[0]     = row_t'(row_x_q);
	assign cfg.rows[1]     = row_t'(row_y_q);
	assign cfg.rows[2]     = row_t'(row_z_q);
	assign cfg.color_order = color_q;

endmodule

`default_nettype wire

FILE: hdl/dpw_backproj.sv
// Back-projection stages 1 to 4: pixel offset, depth product, 1/f product, round and clamp.
// Depends on dpw_pkg for cfg_t, cam_t and the camera clamp constant.
`default_nettype none

module dpw_backproj import dpw_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] col,
	input  logic [COORD_BITS-1:0] row,
	input  logic [15:0]           depth,
	input  logic                  in_box,
	input  logic [7:0]            byte0,
	input  logic [7:0]            byte1,
	input  logic [7:0]            byte2,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cam_t                  cam
);

	localparam int MAG_W   = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
	localparam int DU_W    = MAG_W + 1;
	localparam int P_W     = MAG_W + 16;
	localparam int A_W     = P_W + 16;
	localparam int R_W     = A_W - 3;
	localparam int ROUND_B = 2 ** 19;

	function automatic logic signed [CAM_W-1:0] to_cam(input logic [R_W-1:0] r,
		input logic neg);
		logic [63:0]      r64;
		logic [CAM_W-2:0] mag;
		r64 = 64'(r);
		mag = (r64 > 64'(CAM_MAX)) ? CAM_MAX : r64[CAM_W-2:0];
		return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	logic en_s1, en_s2, en_s3, en_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Stage 1: signed offset from the principal point, split to sign and magnitude.
	logic signed [DU_W-1:0] du_x, du_y;
	side_t                  side_in;

	assign du_x = $signed(DU_W'({col, 4'b0000})) - $signed(DU_W'(cfg.cx));
	assign du_y = $signed(DU_W'({row, 4'b0000})) - $signed(DU_W'(cfg.cy));

	always_comb begin
		side_in.pt = in_box && (depth != 16'd0);
		unique case (cfg.color_order)
			ORDER_BGR: begin
				side_in.red   = byte2;
				side_in.green = byte1;
				side_in.blue  = byte0;
			end
			ORDER_MONO: begin
				side_in.red   = byte0;
				side_in.green = byte0;
				side_in.blue  = byte0;
			end
			default: begin
				side_in.red   = byte0;
				side_in.green = byte1;
				side_in.blue  = byte2;
			end
		endcase
		if (!in_box) begin
			side_in.red   = 8'd0;
			side_in.green = 8'd0;
			side_in.blue  = 8'd0;
		end
	end

	logic [MAG_W-1:0] magx_s1, magy_s1;
	logic             negx_s1, negy_s1;
	logic [15:0]      depth_s1;
	side_t            side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			negx_s1  <= du_x[DU_W-1];
			negy_s1  <= du_y[DU_W-1];
			magx_s1  <= MAG_W'(du_x[DU_W-1] ? -du_x : du_x);
			magy_s1  <= MAG_W'(du_y[DU_W-1] ? -du_y : du_y);
			depth_s1 <= depth;
			side_s1  <= side_in;
		end
	end

	// Stage 2: offset times depth.
	logic [P_W-1:0] px_s2, py_s2;
	logic           negx_s2, negy_s2;
	logic [15:0]    depth_s2;
	side_t          side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			px_s2    <= magx_s1 * depth_s1;
			py_s2    <= magy_s1 * depth_s1;
			negx_s2  <= negx_s1;
			negy_s2  <= negy_s1;
			depth_s2 <= depth_s1;
			side_s2  <= side_s1;
		end
	end

	// Stage 3: multiply by the upper and lower halves of 1/f.
	logic [A_W-1:0] ahx_s3, alx_s3, ahy_s3, aly_s3;
	logic           negx_s3, negy_s3;
	logic [15:0]    depth_s3;
	side_t          side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			ahx_s3   <= px_s2 * cfg.inv_fx[31:16];
			alx_s3   <= px_s2 * cfg.inv_fx[15:0];
			ahy_s3   <= py_s2 * cfg.inv_fy[31:16];
			aly_s3   <= py_s2 * cfg.inv_fy[15:0];
			negx_s3  <= negx_s2;
			negy_s3  <= negy_s2;
			depth_s3 <= depth_s2;
			side_s3  <= side_s2;
		end
	end

	// Stage 4: merge halves with rounding, drop the Q.4 bits, clamp, apply sign.
	logic [A_W-1:0] bsh_x, bsh_y;
	logic [A_W:0]   acc_x, acc_y;

	assign bsh_x = (alx_s3 + A_W'(ROUND_B)) >> 16;
	assign bsh_y = (aly_s3 + A_W'(ROUND_B)) >> 16;
	assign acc_x = {1'b0, ahx_s3} + {1'b0, bsh_x};
	assign acc_y = {1'b0, ahy_s3} + {1'b0, bsh_y};

	cam_t cam_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			cam_s4.side  <= side_s3;
			cam_s4.cam_x <= to_cam(acc_x[A_W:4], negx_s3);
			cam_s4.cam_y <= to_cam(acc_y[A_W:4], negy_s3);
			cam_s4.cam_z <= {depth_s3, 16'd0};
		end
	end

	assign out_valid = v_s4;
	assign cam       = cam_s4;

endmodule

`default_nettype wire

FILE: hdl/dpw_transform.sv
// Rigid transform stages 5 and 6: nine coefficient products, then three row sums.
// Depends on dpw_pkg for cfg_t, cam_t and sum_t.
`default_nettype none

module dpw_transform import dpw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  cam_t cam,
	output logic out_valid,
	input  logic out_ready,
	output sum_t sum
);

	logic en_s5, en_s6;
	logic v_s5, v_s6;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign in_ready = en_s5;

	// Stage 5: products per row (z term, x term, y term).
	logic signed [48:0] pz_s5 [3];
	logic signed [61:0] px_s5 [3];
	logic signed [61:0] py_s5 [3];
	side_t              side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			for (int j = 0; j < 3; j++) begin
				pz_s5[j] <= cfg.rows[j].r0 * $signed({1'b0, cam.cam_z});
				px_s5[j] <= cfg.rows[j].r1 * cam.cam_x;
				py_s5[j] <= cfg.rows[j].r2 * cam.cam_y;
			end
			side_s5 <= cam.side;
		end
	end

	// Stage 6: world = r0*z - r1*x - r2*y + t, all in millimetres Q.30.
	sum_t sum_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6 && v_s5) begin
			for (int j = 0; j < 3; j++) begin
				sum_s6.s[j] <= 64'(pz_s5[j]) - 64'(px_s5[j]) - 64'(py_s5[j])
					+ (64'(cfg.rows[j].t) <<< 30);
			end
			sum_s6.side <= side_s5;
		end
	end

	assign out_valid = v_s6;
	assign sum       = sum_s6;

endmodule

`default_nettype wire

FILE: hdl/dpw_scale.sv
// Metre conversion stages 7 to 12: magnitude, rounding, constant divide, saturation.
// Depends on dpw_pkg for sum_t, point_t and the divider constants; uses the assert macros.
`default_nettype none

`include "depth_pixel_to_world_point_core_assert.svh"

module dpw_scale import dpw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sum_t   sum,
	output logic   out_valid,
	input  logic   out_ready,
	output point_t point
);

	logic en_s7, en_s8, en_s9, en_s10, en_s11, en_s12;
	logic v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	assign en_s12   = !v_s12 || out_ready;
	assign en_s11   = !v_s11 || en_s12;
	assign en_s10   = !v_s10 || en_s11;
	assign en_s9    = !v_s9 || en_s10;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign in_ready = en_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (en_s7)  v_s7  <= in_valid;
			if (en_s8)  v_s8  <= v_s7;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
			if (en_s12) v_s12 <= v_s11;
		end
	end

	// Stage 7: sign and magnitude.
	logic [62:0] m_s7 [3];
	logic [2:0]  neg_s7;
	side_t       side_s7;

	always_ff @(posedge clk) begin
		if (en_s7 && in_valid) begin
			for (int j = 0; j < 3; j++) begin
				neg_s7[j] <= sum.s[j][63];
				m_s7[j]   <= 63'(sum.s[j][63] ? -sum.s[j] : sum.s[j]);
			end
			side_s7 <= sum.side;
		end
	end

	// Stage 8: add half a unit, drop 2^17, flag results beyond the 32-bit range.
	logic [63:0] rnd [3];
	logic [37:0] x_s8 [3];
	logic [2:0]  neg_s8, sat_s8;
	side_t       side_s8;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rnd[j] = 64'(m_s7[j]) + ROUND_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8 && v_s7) begin
			for (int j = 0; j < 3; j++) begin
				sat_s8[j] <= rnd[j][63:15] >= W_SAT;
				x_s8[j]   <= rnd[j][54:17];
			end
			neg_s8  <= neg_s7;
			side_s8 <= side_s7;
		end
	end

	// Stage 9: upper quotient digit of x / 125 by reciprocal.
	logic [38:0] prod_h [3];
	logic [12:0] qh_s9 [3];
	logic [18:0] xh_s9 [3];
	logic [18:0] xl_s9 [3];
	logic [2:0]  neg_s9, sat_s9;
	side_t       side_s9;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			prod_h[j] = x_s8[j][37:19] * RECIP_HI;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9 && v_s8) begin
			for (int j = 0; j < 3; j++) begin
				qh_s9[j] <= prod_h[j][38:26];
				xh_s9[j] <= x_s8[j][37:19];
				xl_s9[j] <= x_s8[j][18:0];
			end
			neg_s9  <= neg_s8;
			sat_s9  <= sat_s8;
			side_s9 <= side_s8;
		end
	end

	// Stage 10: remainder of the upper digit joins the lower half.
	logic [18:0] rh [3];
	logic [25:0] y_s10 [3];
	logic [12:0] qh_s10 [3];
	logic [2:0]  neg_s10, sat_s10;
	side_t       side_s10;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rh[j] = xh_s9[j] - 19'(qh_s9[j]) * 19'(DIV_D);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10 && v_s9) begin
			for (int j = 0; j < 3; j++) begin
				y_s10[j]  <= {rh[j][6:0], xl_s9[j]};
				qh_s10[j] <= qh_s9[j];
			end
			neg_s10  <= neg_s9;
			sat_s10  <= sat_s9;
			side_s10 <= side_s9;
		end
	end

	// Stage 11: lower quotient digit by reciprocal.
	logic [52:0] prod_l [3];
	logic [18:0] ql_s11 [3];
	logic [12:0] qh_s11 [3];
	logic [2:0]  neg_s11, sat_s11;
	side_t       side_s11;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			prod_l[j] = y_s10[j] * RECIP_LO;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s11 && v_s10) begin
			for (int j = 0; j < 3; j++) begin
				ql_s11[j] <= prod_l[j][51:33];
				qh_s11[j] <= qh_s10[j];
			end
			neg_s11  <= neg_s10;
			sat_s11  <= sat_s10;
			side_s11 <= side_s10;
		end
	end

	// Stage 12: output register; apply sign, saturate, zero invalid points.
	logic [31:0] q [3];
	logic [31:0] res [3];
	point_t      point_s12;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			q[j] = {qh_s11[j], ql_s11[j]};
			if (!side_s11.pt) begin
				res[j] = 32'd0;
			end else if (sat_s11[j]) begin
				res[j] = neg_s11[j] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				res[j] = neg_s11[j] ? -q[j] : q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s12 && v_s11) begin
			for (int j = 0; j < 3; j++) begin
				point_s12.world[j] <= res[j];
			end
			point_s12.side <= side_s11;
		end
	end

	assign out_valid = v_s12;
	assign point     = point_s12;

	`DPW_ASSERT_IMP(a_div_rem_bound, v_s10, (y_s10[0] < Y_LIMIT) && (y_s10[1] < Y_LIMIT) && (y_s10[2] < Y_LIMIT), "upper digit remainder not below divisor")

endmodule

`default_nettype wire
